// ===== sv/isd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package isd_pkg;

  // Default framing geometry
  localparam int HEADER_BYTES_DEF  = 64;
  localparam int LENGTH_OFFSET_DEF = 16;
  localparam int FTR_LEN_DEF       = 256;

  // Counter widths cover the full parameter ranges (header up to 127, footer up to 256)
  localparam int HDR_CNT_W = 7;
  localparam int FTR_CNT_W = 9;

  localparam int ADDR_W   = 32;
  localparam int SECTOR_W = 25;

  localparam logic [24:0] SECTOR_BYTES_RST = 25'd4096;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_DATA  = 2'd1,
    OP_END   = 2'd2,
    OP_ABORT = 2'd3
  } opcode_t;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NO_SESSION   = 2'd1;
  localparam logic [1:0] ST_FOOTER_SHORT = 2'd2;

  localparam logic [2:0] RGN_NONE    = 3'd0;
  localparam logic [2:0] RGN_HEADER  = 3'd1;
  localparam logic [2:0] RGN_BODY    = 3'd2;
  localparam logic [2:0] RGN_FOOTER  = 3'd3;
  localparam logic [2:0] RGN_DROPPED = 3'd4;

  // Register indexes on the configuration port
  localparam logic REG_START_ADDRESS = 1'b0;
  localparam logic REG_SECTOR_BYTES  = 1'b1;

  typedef struct packed {
    logic                  session_active;
    logic [HDR_CNT_W-1:0]  header_count;
    logic                  header_done;
    logic [31:0]           body_length;
    logic [31:0]           body_count;
    logic [ADDR_W-1:0]     current_address;
    logic [ADDR_W-1:0]     next_erase_address;
    logic [FTR_CNT_W-1:0]  footer_count;
  } state_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [2:0]        region;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        out_byte;
    logic [7:0]        footer_index;
    logic              erase_request;
    logic [ADDR_W-1:0] erase_address;
    logic              footer_done;
  } step_out_t;

endpackage

`default_nettype wire

// ===== sv/image_stream_deframer_with_erase_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Each accepted item is registered in the output stage and then shown on m_tvalid.
// Throughput: one item per cycle while s_tready is high; all work is a single pass of
// counter compares and increments between the session state registers and the output
// register. A two-entry output stage keeps s_tready high for one item while a result is
// stalled. Reset (rst, synchronous, active high) closes the session, clears all counters
// and addresses, empties the output stage and loads start_address 0, sector_bytes 4096.

module image_stream_deframer_with_erase_unit
  import isd_pkg::*;
#(
  parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
  parameter int LENGTH_OFFSET = LENGTH_OFFSET_DEF,
  parameter int FTR_LEN       = FTR_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // [31:0] write_address, [39:32] out_byte,
                                 // [47:40] footer_index, [48] erase_request,
                                 // [80:49] erase_address, [81] footer_done, rest 0
  output logic [4:0]  m_tuser,   // [1:0] status, [4:2] region
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers; sector_bytes is read live by the erase logic
  logic [ADDR_W-1:0]   start_address;
  logic [SECTOR_W-1:0] sector_bytes;

  state_t    state;
  state_t    state_next;
  step_out_t step_result;
  step_out_t out_result;
  logic      accept;
  logic      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // Register index is taken from the word address bit alone
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= '0;
      sector_bytes  <= SECTOR_BYTES_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_START_ADDRESS: start_address <= pwdata;
        REG_SECTOR_BYTES:  sector_bytes  <= pwdata[SECTOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_START_ADDRESS: prdata = start_address;
      REG_SECTOR_BYTES:  prdata = 32'(sector_bytes);
      default:           prdata = '0;
    endcase
  end

  // Session state advances on every accepted item
  assign accept = s_tvalid && s_tready;

  isd_step #(
    .HEADER_BYTES  (HEADER_BYTES),
    .LENGTH_OFFSET (LENGTH_OFFSET),
    .FTR_LEN       (FTR_LEN)
  ) u_step (
    .state         (state),
    .opcode        (opcode_t'(s_tuser)),
    .data_byte     (s_tdata),
    .start_address (start_address),
    .sector_bytes  (sector_bytes),
    .state_next    (state_next),
    .result        (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Hold results here while the consumer stalls
  isd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (step_result),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tuser = {out_result.region, out_result.status};
  assign m_tdata = {6'd0,
                    out_result.footer_done,
                    out_result.erase_address,
                    out_result.erase_request,
                    out_result.footer_index,
                    out_result.out_byte,
                    out_result.write_address};

endmodule

`default_nettype wire

// ===== sv/isd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isd_step
  import isd_pkg::*;
#(
  parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
  parameter int LENGTH_OFFSET = LENGTH_OFFSET_DEF,
  parameter int FTR_LEN       = FTR_LEN_DEF
) (
  input  state_t              state,
  input  opcode_t             opcode,
  input  logic [7:0]          data_byte,
  input  logic [ADDR_W-1:0]   start_address,
  input  logic [SECTOR_W-1:0] sector_bytes,
  output state_t              state_next,
  output step_out_t           result
);

  localparam logic [HDR_CNT_W-1:0] LEN_LO   = HDR_CNT_W'(LENGTH_OFFSET);
  localparam logic [HDR_CNT_W-1:0] LEN_HI   = HDR_CNT_W'(LENGTH_OFFSET + 4);
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES);
  localparam logic [FTR_CNT_W-1:0] FTR_ALL  = FTR_CNT_W'(FTR_LEN);

  logic [HDR_CNT_W-1:0] hdr_inc;
  logic [1:0]           len_pos;
  logic                 in_len_field;
  logic                 erase_hit;

  assign hdr_inc      = state.header_count + HDR_CNT_W'(1);
  assign len_pos      = 2'(state.header_count - LEN_LO);
  assign in_len_field = (state.header_count >= LEN_LO) && (state.header_count < LEN_HI);
  assign erase_hit    = state.current_address >= state.next_erase_address;

  always_comb begin
    state_next = state;
    result     = '0;
    result.status = ST_OK;
    result.region = RGN_NONE;

    case (opcode)
      OP_BEGIN: begin
        state_next                    = '0;
        state_next.session_active     = 1'b1;
        state_next.current_address    = start_address;
        state_next.next_erase_address = start_address;
      end
      OP_DATA: begin
        if (!state.session_active) begin
          result.status = ST_NO_SESSION;
        end else if (!state.header_done) begin
          result.region = RGN_HEADER;
          // Capture the little-endian body length lane by lane
          if (in_len_field) begin
            case (len_pos)
              2'd0: state_next.body_length[7:0]   = data_byte;
              2'd1: state_next.body_length[15:8]  = data_byte;
              2'd2: state_next.body_length[23:16] = data_byte;
              default: state_next.body_length[31:24] = data_byte;
            endcase
          end
          state_next.header_count = hdr_inc;
          state_next.header_done  = hdr_inc >= HDR_LAST;
        end else if (state.body_count < state.body_length) begin
          result.region        = RGN_BODY;
          result.write_address = state.current_address;
          result.out_byte      = data_byte;
          if (erase_hit) begin
            result.erase_request          = 1'b1;
            result.erase_address          = state.next_erase_address;
            state_next.next_erase_address = state.next_erase_address
                                            + ADDR_W'(sector_bytes);
          end
          state_next.body_count      = state.body_count + 32'd1;
          state_next.current_address = state.current_address + ADDR_W'(1);
        end else if (state.footer_count < FTR_ALL) begin
          result.region           = RGN_FOOTER;
          result.out_byte         = data_byte;
          result.footer_index     = 8'(state.footer_count);
          state_next.footer_count = state.footer_count + FTR_CNT_W'(1);
        end else begin
          result.region = RGN_DROPPED;
        end
      end
      OP_END: begin
        if (!state.session_active) begin
          result.status = ST_NO_SESSION;
        end else begin
          state_next.session_active = 1'b0;
          if (state.footer_count != FTR_ALL) begin
            result.status = ST_FOOTER_SHORT;
          end
        end
      end
      default: begin
        state_next.session_active = 1'b0;
      end
    endcase

    result.footer_done = state_next.footer_count == FTR_ALL;
  end

endmodule

`default_nettype wire

// ===== sv/isd_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isd_skid
  import isd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  step_out_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output step_out_t out_data
);

  logic      skid_valid;
  step_out_t skid_data;
  logic      push;

  assign in_ready = !skid_valid;
  assign push     = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      // Output slot frees up: refill from the skid stage first
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) begin
          out_data <= in_data;
        end
      end
    end else if (push) begin
      skid_data  <= in_data;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import isd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 1050;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  // Input stream
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic [1:0]  s_tuser = OP_BEGIN; // [1:0] opcode

  // Result stream
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;           // [31:0] write_address, [39:32] out_byte,
                                  // [47:40] footer_index, [48] erase_request,
                                  // [80:49] erase_address, [81] footer_done
  logic [4:0]  m_tuser;           // [1:0] status, [4:2] region

  // Configuration port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  image_stream_deframer_with_erase_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Mirror of the deframer's session state and its two registers
  bit          sess_open = 1'b0;
  logic [6:0]  hdr_cnt = '0;
  bit          hdr_done = 1'b0;
  logic [31:0] body_len = '0;
  logic [31:0] body_cnt = '0;
  logic [31:0] cur_addr = '0;
  logic [31:0] erase_next = '0;
  logic [8:0]  ftr_cnt = '0;
  logic [31:0] start_addr = '0;
  logic [24:0] sector_sz = SECTOR_BYTES_RST;

  step_out_t predicted_outputs[$];
  int        failures = 0;
  int        items_sent = 0;
  int        cycles = 0;
  int        rx_stall = 0;
  // When set, both sides run back to back with no idle cycles
  bit        steady = 1'b0;

  // Advance the mirrored state by one item and return the output it causes
  function automatic step_out_t deframe_step(input opcode_t op, input logic [7:0] b);
    step_out_t r;
    int        sh;
    r = '0;
    case (op)
      OP_BEGIN: begin
        sess_open  = 1'b1;
        hdr_cnt    = '0;
        hdr_done   = 1'b0;
        body_len   = '0;
        body_cnt   = '0;
        cur_addr   = start_addr;
        erase_next = start_addr;
        ftr_cnt    = '0;
      end
      OP_DATA: begin
        if (!sess_open) begin
          r.status = ST_NO_SESSION;
        end else if (!hdr_done) begin
          r.region = RGN_HEADER;
          // Capture the little-endian body length from its window in the header
          if (hdr_cnt >= LENGTH_OFFSET_DEF && hdr_cnt < LENGTH_OFFSET_DEF + 4) begin
            sh = 8 * (hdr_cnt - LENGTH_OFFSET_DEF);
            body_len[sh +: 8] = b;
          end
          hdr_cnt = hdr_cnt + 7'd1;
          if (hdr_cnt >= HEADER_BYTES_DEF) hdr_done = 1'b1;
        end else if (body_cnt < body_len) begin
          r.region = RGN_BODY;
          // One erase at most per byte, compared on the wrapped addresses
          if (cur_addr >= erase_next) begin
            r.erase_request = 1'b1;
            r.erase_address = erase_next;
            erase_next = erase_next + {7'd0, sector_sz};
          end
          r.write_address = cur_addr;
          r.out_byte      = b;
          body_cnt = body_cnt + 32'd1;
          cur_addr = cur_addr + 32'd1;
        end else if (ftr_cnt < FTR_LEN_DEF) begin
          r.region       = RGN_FOOTER;
          r.out_byte     = b;
          r.footer_index = ftr_cnt[7:0];
          ftr_cnt = ftr_cnt + 9'd1;
        end else begin
          r.region = RGN_DROPPED;
        end
      end
      OP_END: begin
        if (!sess_open) begin
          r.status = ST_NO_SESSION;
        end else begin
          sess_open = 1'b0;
          if (ftr_cnt != FTR_LEN_DEF) r.status = ST_FOOTER_SHORT;
        end
      end
      default: begin
        // Abort closes the session but keeps every counter
        sess_open = 1'b0;
      end
    endcase
    r.footer_done = (ftr_cnt == FTR_LEN_DEF);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      failures++;
    end
  endtask

  // Compare each accepted result against the oldest prediction, then draw the next stall
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_outputs.size() == 0) begin
        $error("result item with no prediction pending");
        failures++;
      end else begin
        check_field("status", 32'(predicted_outputs[0].status), 32'(m_tuser[1:0]));
        check_field("region", 32'(predicted_outputs[0].region), 32'(m_tuser[4:2]));
        check_field("write_address", predicted_outputs[0].write_address, m_tdata[31:0]);
        check_field("out_byte", 32'(predicted_outputs[0].out_byte), 32'(m_tdata[39:32]));
        check_field("footer_index", 32'(predicted_outputs[0].footer_index),
                    32'(m_tdata[47:40]));
        check_field("erase_request", 32'(predicted_outputs[0].erase_request),
                    32'(m_tdata[48]));
        check_field("erase_address", predicted_outputs[0].erase_address, m_tdata[80:49]);
        check_field("footer_done", 32'(predicted_outputs[0].footer_done), 32'(m_tdata[81]));
        void'(predicted_outputs.pop_front());
      end
      rx_stall = steady ? 0 : $urandom_range(0, 4);
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Offer one item after a random gap, hold it until accepted, then predict its output.
  // Valid stays high on return so back-to-back items need no extra edge.
  task automatic send_item(input opcode_t op, input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    predicted_outputs.push_back(deframe_step(op, b));
    items_sent++;
  endtask

  // Send a data byte, sometimes preceded by a stray command
  task automatic send_byte(input logic [7:0] b, input bit noisy);
    if (noisy && $urandom_range(0, 39) == 0) begin
      send_item(opcode_t'($urandom_range(0, 3)), 8'($urandom));
    end
    send_item(OP_DATA, b);
  endtask

  // Drop valid and hold off until every predicted output has arrived
  task automatic drain_outputs;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (predicted_outputs.size() != 0);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_START_ADDRESS) start_addr = value;
    else sector_sz = value[24:0];
  endtask

  task automatic reg_read(input logic idx, output logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait for the block to go idle, then load both registers and read them back
  task automatic set_layout(input logic [31:0] start, input logic [31:0] sector);
    logic [31:0] rd;
    drain_outputs();
    reg_write(REG_START_ADDRESS, start);
    reg_write(REG_SECTOR_BYTES, sector);
    reg_read(REG_START_ADDRESS, rd);
    check_field("start_address readback", start_addr, rd);
    reg_read(REG_SECTOR_BYTES, rd);
    check_field("sector_bytes readback", {7'd0, sector_sz}, rd);
  endtask

  // One image: header carrying the length, then body_n + tail_n bytes, then a close
  task automatic send_image(input logic [31:0] length, input int unsigned body_n,
                            input int unsigned tail_n, input bit noisy);
    logic [7:0] b;
    send_item(OP_BEGIN, 8'($urandom));
    for (int i = 0; i < HEADER_BYTES_DEF; i++) begin
      b = 8'($urandom);
      if (i >= LENGTH_OFFSET_DEF && i < LENGTH_OFFSET_DEF + 4) begin
        b = length[8 * (i - LENGTH_OFFSET_DEF) +: 8];
      end
      send_byte(b, noisy);
    end
    for (int i = 0; i < body_n + tail_n; i++) send_byte(8'($urandom), noisy);
    // Close mostly with end, now and then with abort
    if ($urandom_range(0, 5) == 0) send_item(OP_ABORT, 8'($urandom));
    else send_item(OP_END, 8'($urandom));
  endtask

  // Commands outside a session, byte extremes included
  task automatic test_idle_commands;
    send_item(OP_DATA, 8'hFF);
    send_item(OP_END, 8'h00);
    send_item(OP_ABORT, 8'hA5);
    send_item(OP_DATA, 8'h00);
  endtask

  // Begin inside a session restarts it; end with a short footer
  task automatic test_restart;
    send_item(OP_BEGIN, 8'h00);
    send_item(OP_DATA, 8'h5A);
    send_item(OP_DATA, 8'h00);
    send_item(OP_BEGIN, 8'hFF);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_END, 8'h3C);
    send_item(OP_DATA, 8'h81);
    send_item(OP_ABORT, 8'h00);
  endtask

  // Abort keeps the counters; a second abort with no session is still ok
  task automatic test_abort;
    send_item(OP_BEGIN, 8'h11);
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'h7F);
    send_item(OP_ABORT, 8'hFF);
    send_item(OP_END, 8'h00);
    send_item(OP_DATA, 8'hC3);
    send_item(OP_ABORT, 8'h00);
    send_item(OP_ABORT, 8'h01);
  endtask

  // Images with random content over a sweep of address and sector settings
  task automatic test_random_images;
    logic [31:0]  start, sector, length;
    int unsigned  body_n, tail_n, pick;
    int           k;
    bit           noisy;
    k = 0;
    while (items_sent < RANDOM_ITEMS) begin
      noisy = ($urandom_range(0, 2) == 0);
      case (k)
        0: begin  // complete image over several small sectors
          start = 32'h0000_1000; sector = 32'd16;
          length = $urandom_range(20, 40); body_n = length; tail_n = 256 + 3; noisy = 0;
        end
        1: begin  // body crosses the top of the address space
          start = 32'hFFFF_FFF0; sector = 32'd1;
          length = 32'd40; body_n = 40; tail_n = 5;
        end
        2: begin  // zero sector size: erase on every body byte
          start = 32'h0000_0000; sector = 32'd0;
          length = 32'd12; body_n = 12; tail_n = 4;
        end
        3: begin  // empty body, complete footer with excess
          start = 32'hFFFF_FFFF; sector = 32'h0100_0000;
          length = 32'd0; body_n = 0; tail_n = 256 + 6;
        end
        4: begin  // huge length, end arrives inside the body
          start = $urandom; sector = 32'h01FF_FFFF;
          length = 32'hFFFF_FFFF; body_n = 18; tail_n = 0;
        end
        5: begin  // upper register bits beyond the sector width are dropped
          start = 32'h7FFF_FFF8; sector = 32'hFE00_0005;
          length = $urandom_range(1, 48); body_n = length; tail_n = $urandom_range(0, 12);
        end
        default: begin
          pick = $urandom_range(0, 5);
          start = (pick == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 30) :
                  (pick == 1) ? 32'h0000_0000 : $urandom;
          pick = $urandom_range(0, 6);
          sector = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1 : (pick == 2) ? 32'd4096 :
                   (pick == 3) ? 32'h01FF_FFFF : (pick == 4) ? $urandom :
                   $urandom_range(2, 24);
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            length = $urandom; body_n = $urandom_range(0, 20); tail_n = 0;
          end else if (pick <= 2) begin
            length = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            body_n = length; tail_n = 256 + $urandom_range(0, 6);
          end else begin
            length = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 48);
            body_n = length; tail_n = $urandom_range(0, 12);
          end
        end
      endcase
      steady = ($urandom_range(0, 3) == 0);
      set_layout(start, sector);
      send_image(length, body_n, tail_n, noisy);
      // Stray commands between images
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) send_item(opcode_t'($urandom_range(0, 3)), 8'($urandom));
      end
      k++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_idle_commands();
    test_restart();
    test_abort();
    test_random_images();
    drain_outputs();
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
